// ----- rtl/core/rmc_pkg.sv -----
`timescale 1ns / 1ps

package rmc_pkg;

  localparam int MENU_SLOTS = 32;
  localparam int USED_SLOTS = (MENU_SLOTS > 32) ? 32 : ((MENU_SLOTS < 1) ? 1 : MENU_SLOTS);
  localparam int SLOT_W     = 5;
  localparam logic [SLOT_W-1:0] TOP_SLOT = SLOT_W'(USED_SLOTS - 1);

  localparam int MASK_W  = 32;
  localparam int TICKS_W = 16;
  localparam int STEPS_W = 8;
  localparam int PRESS_W = 8;
  localparam int RES_W   = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MENU_MASK   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 1'd1;
  localparam logic [TICKS_W-1:0]   LONG_TICKS_RST  = 16'd1000;

  localparam logic [RES_W-1:0] RES_NONE    = 2'd0;
  localparam logic [RES_W-1:0] RES_LONG    = 2'd1;
  localparam logic [RES_W-1:0] RES_SELECT  = 2'd2;
  localparam logic [RES_W-1:0] RES_CHANGED = 2'd3;

  // datapath operations
  localparam logic [2:0] OP_LATCH   = 3'd0;
  localparam logic [2:0] OP_FIND_LO = 3'd1;
  localparam logic [2:0] OP_FIND_HI = 3'd2;
  localparam logic [2:0] OP_CLAMP   = 3'd3;
  localparam logic [2:0] OP_MOVE    = 3'd4;
  localparam logic [2:0] OP_EMIT    = 3'd5;

  // sequencer conditions
  localparam logic [2:0] C_NEVER    = 3'd0;
  localparam logic [2:0] C_ALWAYS   = 3'd1;
  localparam logic [2:0] C_NO_IN    = 3'd2;
  localparam logic [2:0] C_SKIP     = 3'd3;
  localparam logic [2:0] C_MORE     = 3'd4;
  localparam logic [2:0] C_OUT_BUSY = 3'd5;

  localparam int PC_W = 3;

  typedef struct packed {
    logic [2:0]      op;
    logic [2:0]      hold;
    logic [2:0]      br;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic skip_move;
    logic move_more;
    logic out_busy;
  } seq_status_t;

  localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
  localparam logic [PC_W-1:0] PC_MOVE = 3'd4;
  localparam logic [PC_W-1:0] PC_EMIT = 3'd5;

  function automatic ctrl_word_t rmc_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    begin
      w = '{op: OP_EMIT, hold: C_NEVER, br: C_ALWAYS, target: PC_IDLE};
      case (pc)
        3'd0: w = '{op: OP_LATCH,   hold: C_NO_IN,    br: C_NEVER,  target: PC_IDLE};
        3'd1: w = '{op: OP_FIND_LO, hold: C_NEVER,    br: C_NEVER,  target: PC_IDLE};
        3'd2: w = '{op: OP_FIND_HI, hold: C_NEVER,    br: C_NEVER,  target: PC_IDLE};
        3'd3: w = '{op: OP_CLAMP,   hold: C_NEVER,    br: C_SKIP,   target: PC_EMIT};
        3'd4: w = '{op: OP_MOVE,    hold: C_MORE,     br: C_NEVER,  target: PC_IDLE};
        3'd5: w = '{op: OP_EMIT,    hold: C_OUT_BUSY, br: C_ALWAYS, target: PC_IDLE};
        default: w = '{op: OP_EMIT, hold: C_NEVER,    br: C_ALWAYS, target: PC_IDLE};
      endcase
      return w;
    end
  endfunction

  localparam logic [MASK_W-1:0] USED_MASK = {MASK_W{1'b1}} >> (MASK_W - USED_SLOTS);

  function automatic logic [MASK_W-1:0] slots_below(input logic [SLOT_W-1:0] i);
    return (MASK_W'(1) << i) - MASK_W'(1);
  endfunction

  function automatic logic [MASK_W-1:0] slots_above(input logic [SLOT_W-1:0] i);
    return ~((MASK_W'(2) << i) - MASK_W'(1));
  endfunction

  function automatic logic [SLOT_W-1:0] lowest_set(input logic [MASK_W-1:0] v);
    logic [SLOT_W-1:0] r;
    begin
      r = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
        if (v[i]) r = SLOT_W'(i);
      end
      return r;
    end
  endfunction

  function automatic logic [SLOT_W-1:0] highest_set(input logic [MASK_W-1:0] v);
    logic [SLOT_W-1:0] r;
    begin
      r = '0;
      for (int i = 0; i < MASK_W; i++) begin
        if (v[i]) r = SLOT_W'(i);
      end
      return r;
    end
  endfunction

endpackage

// ----- rtl/core/rmc_seq.sv -----
`timescale 1ns / 1ps

module rmc_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  rmc_pkg::seq_status_t status,
  output logic [2:0]          op
);
  import rmc_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  ctrl_word_t      word;
  logic            hold_c, br_c;

  function automatic logic cond_eval(input logic [2:0] c, input seq_status_t s);
    logic r;
    begin
      r = 1'b0;
      unique case (c)
        C_NEVER:    r = 1'b0;
        C_ALWAYS:   r = 1'b1;
        C_NO_IN:    r = !s.in_valid;
        C_SKIP:     r = s.skip_move;
        C_MORE:     r = s.move_more;
        C_OUT_BUSY: r = s.out_busy;
        default:    r = 1'b0;
      endcase
      return r;
    end
  endfunction

  always_comb begin
    word   = rmc_rom(pc_r);
    hold_c = cond_eval(word.hold, status);
    br_c   = cond_eval(word.br, status);
    if (hold_c) begin
      pc_nxt = pc_r;
    end else if (br_c) begin
      pc_nxt = word.target;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  assign op = word.op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- rtl/core/rotary_menu_cursor.sv -----
`timescale 1ns / 1ps

// Menu cursor for a rotary encoder with push button.
// in_*: one transfer per encoder report. in_tdata carries rotation, press
// count and held time; in_tuser carries the button-held flag.
// out_*: one transfer per report: the menu event and the cursor slot after it.
// cfg_*: write-only registers; index 0 is the slot enable mask, index 1 the
// long-press threshold. Write them only while the block is idle.
// A microcoded sequencer steps a small datapath: latch, find lowest enabled
// slot, find highest, snap and clamp the cursor, then one slot move per cycle
// with a priority encoder, then emit. Each move lands on a new slot, so a
// report makes at most 31 moves.
// in_tready is high only while the sequencer waits for a report; the output
// register lets the next report be taken while a result still waits.
// If the receiver stalls, the sequencer holds at the emit step.
// Reset clears the cursor to slot 0, the mask to zero and sets the
// long-press threshold to 1000 ticks.
module rotary_menu_cursor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // rotary_steps, press_count, held_time
  input  logic                            in_tuser,   // button_down
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // menu_result, cursor_slot
  input  logic                            cfg_we,
  input  logic [rmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rmc_pkg::MASK_W-1:0]      cfg_wdata
);
  import rmc_pkg::*;

  logic [MASK_W-1:0]  mask_r;
  logic [TICKS_W-1:0] ticks_r;

  logic [STEPS_W-1:0] rot_r;
  logic [PRESS_W-1:0] press_r;
  logic               down_r;
  logic [TICKS_W-1:0] held_r;

  logic [SLOT_W-1:0]  cursor_r, cursor_nxt;
  logic [SLOT_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [STEPS_W-1:0] mag_r, mag_nxt;
  logic [RES_W-1:0]   res_r, res_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]   out_res_r, out_res_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;

  logic [2:0]         op;
  seq_status_t        status;

  logic [MASK_W-1:0]  lo_cand, hi_cand, dn_cand, up_cand;
  logic [SLOT_W-1:0]  snap, clamp_lo, clamp;
  logic               long_press, no_move, rot_neg;
  logic [SLOT_W-1:0]  step_slot;
  logic               move_done;

  rmc_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .op     (op)
  );

  assign in_tready = (op == OP_LATCH);
  assign rot_neg   = rot_r[STEPS_W-1];

  always_comb begin
    lo_cand    = mask_r & USED_MASK & slots_below(TOP_SLOT);
    hi_cand    = mask_r & USED_MASK & slots_above(lo_r);
    snap       = (cursor_r == '0) ? lo_r : cursor_r;
    clamp_lo   = (snap < lo_r) ? lo_r : snap;
    clamp      = (clamp_lo > hi_r) ? hi_r : clamp_lo;
    long_press = down_r && (held_r >= ticks_r);
    no_move    = (rot_r == '0) || (rot_neg && clamp == lo_r) || (!rot_neg && clamp == hi_r);

    dn_cand = mask_r & slots_below(cursor_r) & slots_above(lo_r);
    up_cand = mask_r & slots_above(cursor_r) & slots_below(hi_r);
    if (rot_neg) begin
      step_slot = (dn_cand != '0) ? highest_set(dn_cand) : lo_r;
      move_done = (step_slot == lo_r) || (mag_r == STEPS_W'(1));
    end else begin
      step_slot = (up_cand != '0) ? lowest_set(up_cand) : hi_r;
      move_done = (step_slot == hi_r) || (mag_r == STEPS_W'(1));
    end
  end

  always_comb begin
    status.in_valid  = in_tvalid;
    status.skip_move = long_press || (press_r != '0) || no_move;
    status.move_more = !move_done;
    status.out_busy  = out_valid_r && !out_tready;
  end

  always_comb begin
    cursor_nxt    = cursor_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mag_nxt       = mag_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    out_slot_nxt  = out_slot_r;
    unique case (op)
      OP_LATCH: begin
      end
      OP_FIND_LO: begin
        lo_nxt = (lo_cand != '0) ? lowest_set(lo_cand) : TOP_SLOT;
      end
      OP_FIND_HI: begin
        hi_nxt = (hi_cand != '0) ? highest_set(hi_cand) : lo_r;
      end
      OP_CLAMP: begin
        cursor_nxt = clamp;
        mag_nxt    = rot_neg ? (STEPS_W'(0) - rot_r) : rot_r;
        if (long_press) begin
          res_nxt = RES_LONG;
        end else if (press_r != '0) begin
          res_nxt = RES_SELECT;
        end else if (no_move) begin
          res_nxt = RES_NONE;
        end else begin
          res_nxt = RES_CHANGED;
        end
      end
      OP_MOVE: begin
        cursor_nxt = step_slot;
        mag_nxt    = mag_r - STEPS_W'(1);
      end
      OP_EMIT: begin
        if (!status.out_busy) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_slot_nxt  = cursor_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      ticks_r     <= LONG_TICKS_RST;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MENU_MASK) mask_r <= cfg_wdata;
        if (cfg_index == CFG_LONG_TICKS) ticks_r <= cfg_wdata[TICKS_W-1:0];
      end
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      rot_r   <= in_tdata[7:0];
      press_r <= in_tdata[15:8];
      held_r  <= in_tdata[31:16];
      down_r  <= in_tuser;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mag_r      <= mag_nxt;
    res_r      <= res_nxt;
    out_res_r  <= out_res_nxt;
    out_slot_r <= out_slot_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_slot_r, out_res_r};

  a_no_double_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken twice in a row");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_EMIT) |-> (cursor_r >= lo_r && cursor_r <= hi_r))
    else $error("cursor outside enabled range at emit");

  a_move_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_MOVE) |-> (mag_r != '0))
    else $error("move step with no rotation left");

  a_move_is_change: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_MOVE) |-> (res_r == RES_CHANGED))
    else $error("move step without changed result");

endmodule
